>>> design/mwt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mwt_pkg;

  localparam int unsigned MWT_TABLE_ENTRIES = 16;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned INDEX_W = 4;

  localparam int unsigned FLAG_RANGE = 0;
  localparam int unsigned FLAG_READ = 1;
  localparam int unsigned FLAG_WRITE = 2;
  localparam int unsigned FLAG_LOG = 3;
  localparam int unsigned FLAG_BREAK = 4;
  localparam int unsigned FLAGS_W = 5;

  typedef enum logic [1:0] {
    REQ_ACCESS = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NOP    = 2'd3
  } req_kind_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_COVERED   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } back_state_e;

  typedef struct packed {
    req_kind_e           kind;
    logic [ADDR_W-1:0]   address;
    logic [ADDR_W-1:0]   end_address;
    logic [FLAGS_W-1:0]  flags;
    logic                is_write;
  } item_t;

  typedef struct packed {
    logic                matched;
    logic [INDEX_W-1:0]  match_index;
    logic                do_log;
    logic                do_break;
    status_e             status;
  } result_t;

endpackage

`default_nettype wire

>>> design/memory_watchpoint_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Bits  Contents
// s_axis    in   72    tdata: request fields; tuser: request type
// m_axis    out  16    tdata: one result for every request
//
// In the table, all entries are first compared with a request in parallel
// and the hits registered; then the first hit is resolved and the table updated.
// A two-item queue sits between the input side and the table, and an
// output register holds the result while the table takes the next item.
// Reset empties the table and the queue; entries hold no reset value.

module memory_watchpoint_table_unit #(
  parameter int unsigned TABLE_ENTRIES = mwt_pkg::MWT_TABLE_ENTRIES
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // address[31:0], end_address[63:32], range_mode[64], watch_read[65],
  // watch_write[66], log_enable[67], break_enable[68], is_write[69], zero pad.
  input  wire logic [71:0]  s_axis_tdata,
  // req_type[1:0].
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // matched[0], match_index[4:1], do_log[5], do_break[6], status[8:7], zero pad.
  output logic [15:0]       m_axis_tdata
);
  import mwt_pkg::*;

  logic     item_valid;
  logic     item_pop;
  item_t    item;
  result_t  result;

  mwt_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .req_type_i     (s_axis_tuser),
    .address_i      (s_axis_tdata[31:0]),
    .end_address_i  (s_axis_tdata[63:32]),
    .range_mode_i   (s_axis_tdata[64]),
    .watch_read_i   (s_axis_tdata[65]),
    .watch_write_i  (s_axis_tdata[66]),
    .log_enable_i   (s_axis_tdata[67]),
    .break_enable_i (s_axis_tdata[68]),
    .is_write_i     (s_axis_tdata[69]),
    .item_valid_o   (item_valid),
    .item_pop_i     (item_pop),
    .item_o         (item)
  );

  mwt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .item_i       (item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .result_o     (result)
  );

  assign m_axis_tdata = {7'd0, result.status, result.do_break, result.do_log,
                         result.match_index, result.matched};

endmodule

`default_nettype wire

>>> design/mwt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mwt_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [1:0]     req_type_i,
  input  wire logic [31:0]    address_i,
  input  wire logic [31:0]    end_address_i,
  input  wire logic           range_mode_i,
  input  wire logic           watch_read_i,
  input  wire logic           watch_write_i,
  input  wire logic           log_enable_i,
  input  wire logic           break_enable_i,
  input  wire logic           is_write_i,
  output logic                item_valid_o,
  input  wire logic           item_pop_i,
  output mwt_pkg::item_t      item_o
);
  import mwt_pkg::*;

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            item_new;
  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push;
  logic             pop;

  // Classify the request and prepare the entry as the table stores it.
  always_comb begin
    item_new.kind = req_kind_e'(req_type_i);
    item_new.address = address_i;
    item_new.end_address = range_mode_i ? end_address_i : address_i;
    item_new.flags[FLAG_RANGE] = range_mode_i;
    item_new.flags[FLAG_READ] = watch_read_i;
    item_new.flags[FLAG_WRITE] = watch_write_i;
    item_new.flags[FLAG_LOG] = log_enable_i;
    item_new.flags[FLAG_BREAK] = break_enable_i;
    item_new.is_write = is_write_i;
  end

  assign in_ready_o = (cnt_q != CntW'(Depth));
  assign push = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != '0);
  assign pop = item_pop_i && item_valid_o;
  assign item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

`default_nettype wire

>>> design/mwt_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mwt_back #(
  parameter int unsigned TABLE_ENTRIES = mwt_pkg::MWT_TABLE_ENTRIES
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           item_valid_i,
  output logic                item_pop_o,
  input  wire mwt_pkg::item_t item_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output mwt_pkg::result_t    result_o
);
  import mwt_pkg::*;

  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  back_state_e          state_q, state_d;
  item_t                item_q;
  logic [CntW-1:0]      count_q, count_d;
  logic [ADDR_W-1:0]    start_q [TABLE_ENTRIES];
  logic [ADDR_W-1:0]    end_q [TABLE_ENTRIES];
  logic [FLAGS_W-1:0]   flags_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] cover_d, cover_q;
  logic [TABLE_ENTRIES-1:0] same_d, same_q;
  logic [TABLE_ENTRIES-1:0] cover_first;
  logic [TABLE_ENTRIES-1:0] same_at_or_below;
  logic                 seen_cover;
  logic                 seen_same;
  logic [INDEX_W-1:0]   cover_index;
  logic [FLAGS_W-1:0]   cover_flags;
  logic                 covered;
  logic                 found;
  logic                 full;
  logic                 trig;
  logic                 exec_fire;
  logic                 do_add;
  logic                 do_remove;
  logic                 out_valid_q, out_valid_d;
  result_t              result_q, result_d;

  // Each cell compares the head item against its own entry.
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      logic live;
      logic in_range;
      live = (CntW'(i) < count_q);
      in_range = (item_i.address >= start_q[i]) && (item_i.address <= end_q[i]);
      cover_d[i] = live && (flags_q[i][FLAG_RANGE] ? in_range
                                                     : (start_q[i] == item_i.address));
      same_d[i] = live && (start_q[i] == item_i.address);
    end
  end

  // Resolve the first hit among the registered compare results.
  always_comb begin
    cover_index = '0;
    cover_flags = '0;
    seen_cover = 1'b0;
    seen_same = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      cover_first[i] = cover_q[i] && !seen_cover;
      seen_cover = seen_cover | cover_q[i];
      seen_same = seen_same | same_q[i];
      same_at_or_below[i] = seen_same;
      if (cover_first[i]) begin
        cover_index = INDEX_W'(i);
        cover_flags = flags_q[i];
      end
    end
  end

  assign covered = |cover_q;
  assign found = |same_q;
  assign full = (count_q >= CntW'(TABLE_ENTRIES));
  assign trig = item_q.is_write ? cover_flags[FLAG_WRITE] : cover_flags[FLAG_READ];
  assign exec_fire = (state_q == BK_EXEC) && (!out_valid_q || out_ready_i);
  assign do_add = exec_fire && (item_q.kind == REQ_ADD) && !covered && !full;
  assign do_remove = exec_fire && (item_q.kind == REQ_REMOVE) && found;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (item_valid_i) begin
          state_d = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (exec_fire) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    item_pop_o = 1'b0;
    case (state_q)
      BK_IDLE: item_pop_o = item_valid_i;
      BK_EXEC: item_pop_o = 1'b0;
      default: item_pop_o = 1'b0;
    endcase
  end

  always_comb begin
    result_d = '0;
    result_d.status = ST_DONE;
    case (item_q.kind)
      REQ_ACCESS: begin
        result_d.matched = covered;
        result_d.match_index = cover_index;
        result_d.do_log = covered && trig && cover_flags[FLAG_LOG];
        result_d.do_break = covered && trig && cover_flags[FLAG_BREAK];
      end
      REQ_ADD: begin
        if (covered) begin
          result_d.status = ST_COVERED;
        end else if (full) begin
          result_d.status = ST_FULL;
        end
      end
      REQ_REMOVE: begin
        if (!found) begin
          result_d.status = ST_NOT_FOUND;
        end
      end
      default: result_d.status = ST_DONE;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (do_add) begin
      count_d = count_q + 1'b1;
    end else if (do_remove) begin
      count_d = count_q - 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      item_q <= item_i;
      cover_q <= cover_d;
      same_q <= same_d;
    end
    if (exec_fire) begin
      result_q <= result_d;
    end
  end

  // A removal shifts every entry above the removed one down by one place.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (do_add && (CntW'(i) == count_q)) begin
        start_q[i] <= item_q.address;
        end_q[i] <= item_q.end_address;
        flags_q[i] <= item_q.flags;
      end else if (do_remove && same_at_or_below[i] && (i + 1 < TABLE_ENTRIES)) begin
        start_q[i] <= start_q[(i + 1) % TABLE_ENTRIES];
        end_q[i] <= end_q[(i + 1) % TABLE_ENTRIES];
        flags_q[i] <= flags_q[(i + 1) % TABLE_ENTRIES];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mwt_pkg::*;

  localparam int unsigned ITEM_TARGET = 650;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [FLAGS_W-1:0] WP_RANGE = FLAGS_W'(1 << FLAG_RANGE);
  localparam logic [FLAGS_W-1:0] WP_READ = FLAGS_W'(1 << FLAG_READ);
  localparam logic [FLAGS_W-1:0] WP_WRITE = FLAGS_W'(1 << FLAG_WRITE);
  localparam logic [FLAGS_W-1:0] WP_LOG = FLAGS_W'(1 << FLAG_LOG);
  localparam logic [FLAGS_W-1:0] WP_BREAK = FLAGS_W'(1 << FLAG_BREAK);

  typedef enum int unsigned {
    PH_FILL  = 0,
    PH_MIX   = 1,
    PH_DRAIN = 2
  } phase_e;

  class watch_table_checker;
    logic [ADDR_W-1:0]  wp_start [MWT_TABLE_ENTRIES];
    logic [ADDR_W-1:0]  wp_end   [MWT_TABLE_ENTRIES];
    logic [FLAGS_W-1:0] wp_flags [MWT_TABLE_ENTRIES];
    int unsigned wp_count;
    result_t expected_results[$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned responses;
    int unsigned hits;
    int unsigned triggers;
    int unsigned covered_adds;
    int unsigned full_adds;
    int unsigned missed_removes;

    function new();
      wp_count = 0;
      mismatches = 0;
      requests = 0;
      responses = 0;
      hits = 0;
      triggers = 0;
      covered_adds = 0;
      full_adds = 0;
      missed_removes = 0;
    endfunction

    function int unsigned first_cover(logic [ADDR_W-1:0] addr);
      int unsigned i;
      for (i = 0; i < wp_count; i++) begin
        if (wp_flags[i][FLAG_RANGE]) begin
          if (addr >= wp_start[i] && addr <= wp_end[i]) return i;
        end else if (wp_start[i] == addr) begin
          return i;
        end
      end
      return wp_count;
    endfunction

    function string show(result_t r);
      return $sformatf("matched=%0b index=%0d log=%0b break=%0b status=%0d",
                       r.matched, r.match_index, r.do_log, r.do_break, r.status);
    endfunction

    function void note_failure(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void predict_request(logic [1:0] kind_bits, logic [71:0] data);
      logic [ADDR_W-1:0]  addr;
      logic [ADDR_W-1:0]  end_addr;
      logic [FLAGS_W-1:0] flags;
      logic               is_wr;
      logic               trig;
      int unsigned        pos;
      int unsigned        i;
      result_t            res;
      addr = data[31:0];
      end_addr = data[63:32];
      flags = data[68:64];
      is_wr = data[69];
      res = '0;
      case (req_kind_e'(kind_bits))
        REQ_ACCESS: begin
          pos = first_cover(addr);
          if (pos < wp_count) begin
            res.matched = 1'b1;
            res.match_index = pos[INDEX_W-1:0];
            trig = is_wr ? wp_flags[pos][FLAG_WRITE] : wp_flags[pos][FLAG_READ];
            hits++;
            if (trig) begin
              res.do_log = wp_flags[pos][FLAG_LOG];
              res.do_break = wp_flags[pos][FLAG_BREAK];
              triggers++;
            end
          end
        end
        REQ_ADD: begin
          if (first_cover(addr) < wp_count) begin
            res.status = ST_COVERED;
            covered_adds++;
          end else if (wp_count >= MWT_TABLE_ENTRIES) begin
            res.status = ST_FULL;
            full_adds++;
          end else begin
            wp_start[wp_count] = addr;
            wp_end[wp_count] = flags[FLAG_RANGE] ? end_addr : addr;
            wp_flags[wp_count] = flags;
            wp_count++;
          end
        end
        REQ_REMOVE: begin
          pos = 0;
          while (pos < wp_count && wp_start[pos] != addr) pos++;
          if (pos >= wp_count) begin
            res.status = ST_NOT_FOUND;
            missed_removes++;
          end else begin
            for (i = pos; i + 1 < wp_count; i++) begin
              wp_start[i] = wp_start[i + 1];
              wp_end[i] = wp_end[i + 1];
              wp_flags[i] = wp_flags[i + 1];
            end
            wp_count--;
          end
        end
        default: begin
        end
      endcase
      requests++;
      expected_results = {expected_results, res};
    endfunction

    function void check_response(logic [15:0] data);
      result_t got;
      result_t want;
      got.matched = data[0];
      got.match_index = data[4:1];
      got.do_log = data[5];
      got.do_break = data[6];
      got.status = status_e'(data[8:7]);
      responses++;
      if (expected_results.size() == 0) begin
        note_failure($sformatf("result with no request waiting: %s", show(got)));
      end else begin
        want = expected_results.pop_front();
        if (got.matched !== want.matched || got.match_index !== want.match_index ||
            got.do_log !== want.do_log || got.do_break !== want.do_break ||
            got.status !== want.status) begin
          note_failure($sformatf("expected %s, got %s", show(want), show(got)));
        end
      end
    endfunction

    function void final_check();
      if (expected_results.size() != 0)
        note_failure($sformatf("%0d expected results never arrived",
                               expected_results.size()));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  logic              no_idle = 1'b0;
  logic [ADDR_W-1:0] region_base = 32'h0000_4000;

  watch_table_checker sb = new();

  memory_watchpoint_table_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Run stopped by the watchdog.");
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_response(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.predict_request(s_axis_tuser, s_axis_tdata);
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : result_sink
    int unsigned len;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      len = pick_gap();
      if (len == 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        repeat (len) @(posedge clk_i);
      end
    end
  end

  task automatic send_req(input req_kind_e kind, input logic [ADDR_W-1:0] addr,
                          input logic [ADDR_W-1:0] end_addr,
                          input logic [FLAGS_W-1:0] flags, input logic is_wr);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {2'b00, is_wr, flags, end_addr, addr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    int unsigned r;
    int unsigned i;
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] e;
    r = $urandom_range(0, 99);
    if (r < 40 && sb.wp_count > 0) begin
      i = $urandom_range(0, sb.wp_count - 1);
      s = sb.wp_start[i];
      e = sb.wp_end[i];
      case ($urandom_range(0, 4))
        0: return s;
        1: return e;
        2: return e + 1;
        3: return s - 1;
        default: return (e >= s) ? s + ((e - s) >> 1) : s;
      endcase
    end
    if (r < 75) return region_base + $urandom_range(0, 63);
    if (r < 88) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h0000_0001;
        default: return 32'hFFFF_FFFE;
      endcase
    end
    return $urandom;
  endfunction

  task automatic build_request(input phase_e ph, output req_kind_e kind,
                               output logic [ADDR_W-1:0] addr,
                               output logic [ADDR_W-1:0] end_addr,
                               output logic [FLAGS_W-1:0] flags, output logic is_wr);
    int unsigned r;
    int unsigned add_cut;
    int unsigned access_cut;
    int unsigned remove_cut;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        add_cut = 75;
        access_cut = 93;
        remove_cut = 97;
      end
      PH_MIX: begin
        add_cut = 22;
        access_cut = 72;
        remove_cut = 95;
      end
      default: begin
        add_cut = 8;
        access_cut = 41;
        remove_cut = 96;
      end
    endcase
    if (r < add_cut) kind = REQ_ADD;
    else if (r < access_cut) kind = REQ_ACCESS;
    else if (r < remove_cut) kind = REQ_REMOVE;
    else kind = REQ_NOP;

    if (kind == REQ_REMOVE && sb.wp_count > 0 && $urandom_range(0, 9) < 7)
      addr = sb.wp_start[$urandom_range(0, sb.wp_count - 1)];
    else
      addr = pick_addr();

    flags = FLAGS_W'($urandom_range(0, 31));
    is_wr = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (!flags[FLAG_RANGE] || r >= 85) end_addr = $urandom;
    else if (r < 60) end_addr = addr + $urandom_range(0, 32);
    else if (r < 75) end_addr = addr - $urandom_range(1, 8);
    else end_addr = 32'hFFFF_FFFF;
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned guard;
    phase_e ph;
    req_kind_e kind;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] end_addr;
    logic [FLAGS_W-1:0] flags;
    logic is_wr;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, then singles at both address extremes, a range and an inverted range.
    send_req(REQ_ACCESS, 32'h0000_0000, 32'h0000_0000, '0, 1'b0);
    send_req(REQ_REMOVE, 32'h0000_0000, 32'h0000_0000, '0, 1'b0);
    send_req(REQ_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, 1'b1);
    send_req(REQ_ADD, 32'h0000_0000, 32'h1234_5678, WP_READ | WP_WRITE | WP_LOG | WP_BREAK,
             1'b0);
    send_req(REQ_ADD, 32'hFFFF_FFFF, 32'h0000_0000, WP_WRITE | WP_BREAK, 1'b1);
    send_req(REQ_ADD, 32'h0000_1000, 32'h0000_10FF, WP_RANGE | WP_READ | WP_LOG, 1'b0);
    send_req(REQ_ADD, 32'h0000_2000, 32'h0000_1FFF, '1, 1'b0);
    send_req(REQ_ADD, 32'h0000_1080, 32'h0000_0000, WP_READ, 1'b0);
    send_req(REQ_ADD, 32'h0000_0000, 32'hFFFF_FFFF, '1, 1'b0);
    send_req(REQ_ACCESS, 32'h0000_0000, '0, '0, 1'b1);
    send_req(REQ_ACCESS, 32'hFFFF_FFFF, '0, '0, 1'b0);
    send_req(REQ_ACCESS, 32'hFFFF_FFFF, '0, '0, 1'b1);
    send_req(REQ_ACCESS, 32'h0000_1000, '0, '0, 1'b0);
    send_req(REQ_ACCESS, 32'h0000_10FF, '0, '0, 1'b1);
    send_req(REQ_ACCESS, 32'h0000_1100, '0, '0, 1'b0);
    send_req(REQ_ACCESS, 32'h0000_2000, '0, '0, 1'b0);
    send_req(REQ_ACCESS, 32'h0000_1FFF, '0, '0, 1'b1);
    send_req(REQ_REMOVE, 32'h0000_1000, '0, '0, 1'b0);
    send_req(REQ_ACCESS, 32'hFFFF_FFFF, '0, '0, 1'b1);
    send_req(REQ_ACCESS, 32'h0000_1080, '0, '0, 1'b0);
    send_req(REQ_REMOVE, 32'h0000_1080, '0, '0, 1'b0);
    send_req(REQ_ADD, 32'h0000_0005, 32'hFFFF_FFFF, WP_RANGE | WP_READ | WP_WRITE | WP_LOG,
             1'b0);
    send_req(REQ_ACCESS, 32'h0000_0007, '0, '0, 1'b1);
    send_req(REQ_ACCESS, 32'hFFFF_FFFF, '0, '0, 1'b0);
    send_req(REQ_NOP, '0, '0, '0, 1'b0);
    wait_drained();

    sent = 0;
    while (sent < ITEM_TARGET) begin
      ph = phase_e'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
        0: region_base = 32'h0000_0000;
        1: region_base = 32'hFFFF_FFC0;
        default: region_base = $urandom & 32'hFFFF_FF00;
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(20, 60)) begin
        build_request(ph, kind, addr, end_addr, flags, is_wr);
        send_req(kind, addr, end_addr, flags, is_wr);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
    no_idle = 1'b0;

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    guard = 0;
    while (sb.expected_results.size() != 0 && guard < 50_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
    sb.final_check();

    $display("Sent %0d requests and saw %0d results: %0d hits, %0d triggered.",
             sb.requests, sb.responses, sb.hits, sb.triggers);
    $display("Adds refused as covered %0d, as full %0d; removes not found %0d; failures %0d.",
             sb.covered_adds, sb.full_adds, sb.missed_removes, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
